@@ hw/rtl/cfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfp_pkg
// Types and constants shared by the command frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam logic [7:0] StartMarkerRst = 8'hBD;
  localparam logic [7:0] BlinkLength    = 8'd3;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_CMD     = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DROP    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_SUM_OK        = 3'd0,
    ST_BLINK_OK      = 3'd1,
    ST_TOO_SHORT     = 3'd2,
    ST_BAD_START     = 3'd3,
    ST_BAD_BLINK_LEN = 3'd4,
    ST_UNKNOWN_CMD   = 3'd5,
    ST_TRUNCATED     = 3'd6
  } status_e;

  typedef enum logic [0:0] {
    CMD_SUM   = 1'b0,
    CMD_FLASH = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] byte_total;
    logic [7:0]  on_time;
    logic [7:0]  off_time;
    logic [7:0]  repeat_total;
  } out_word_t;

endpackage

@@ hw/rtl/command_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// command_frame_parser_core
// Byte-serial command frame parser with one status word per frame.
//
// Takes one frame byte per cycle: every byte is parsed in the cycle it is
// accepted (a compare or one 16-bit add against the frame state), and a
// status word, when the byte settles the outcome, lands in the output register.
// A two-entry output stage (output register plus skid register) keeps the
// input ready while a word waits on the output, so a full byte per cycle is
// sustained unless the output stalls for two words. Bytes after a frame's
// status word are dropped up to frame_end. The user must write the start
// marker through the config channel only while idle; the block does not check.
// ----------------------------------------------------------------------------
module command_frame_parser_core import cfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic [7:0]  marker_q;
  phase_e      phase_q, phase_d;
  cmd_e        kind_q, kind_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  seen_q, seen_d;
  logic [15:0] total_q, total_d;
  logic [7:0]  on_q, on_d;
  logic [7:0]  off_q, off_d;

  logic        res_vld;
  out_word_t   res;
  logic [15:0] sum;
  logic [7:0]  b;
  logic        last;
  logic        in_fire, out_fire;

  logic        out_vld_q, skid_vld_q;
  out_word_t   out_q, skid_q;

  assign b        = in_data_i.data_byte;
  assign last     = in_data_i.frame_end;
  assign in_ready_o  = !skid_vld_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_fire    = out_vld_q && out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign sum         = total_q + {8'd0, b};

  // Frame datapath and result
  always_comb begin
    res_vld = 1'b0;
    res     = '0;
    kind_d  = kind_q;
    len_d   = len_q;
    seen_d  = seen_q;
    total_d = total_q;
    on_d    = on_q;
    off_d   = off_q;
    unique case (phase_q)
      PH_START: begin
        if (last) begin
          res_vld = 1'b1;
          res.status = ST_TOO_SHORT;
        end else if (b != marker_q) begin
          res_vld = 1'b1;
          res.status = ST_BAD_START;
        end
      end
      PH_CMD: begin
        if (b > 8'd1) begin
          res_vld = 1'b1;
          res.status = ST_UNKNOWN_CMD;
        end else if (last) begin
          res_vld = 1'b1;
          res.status = ST_TRUNCATED;
        end else begin
          kind_d = cmd_e'(b[0]);
        end
      end
      PH_LEN: begin
        len_d   = b;
        seen_d  = '0;
        total_d = '0;
        if (kind_q == CMD_FLASH) begin
          if (b != BlinkLength) begin
            res_vld = 1'b1;
            res.status = ST_BAD_BLINK_LEN;
          end else if (last) begin
            res_vld = 1'b1;
            res.status = ST_TRUNCATED;
          end
        end else if (b == 8'd0) begin
          res_vld = 1'b1;
          res.status = ST_SUM_OK;
        end else if (last) begin
          res_vld = 1'b1;
          res.status = ST_TRUNCATED;
        end
      end
      PH_PAYLOAD: begin
        seen_d = seen_q + 8'd1;
        if (kind_q == CMD_FLASH) begin
          if (seen_q >= 8'd2) begin
            res_vld = 1'b1;
            res.status       = ST_BLINK_OK;
            res.on_time      = on_q;
            res.off_time     = off_q;
            res.repeat_total = b;
          end else begin
            if (seen_q == 8'd0) begin
              on_d = b;
            end else begin
              off_d = b;
            end
            if (last) begin
              res_vld = 1'b1;
              res.status = ST_TRUNCATED;
            end
          end
        end else begin
          total_d = sum;
          if (seen_d == len_q) begin
            res_vld = 1'b1;
            res.status     = ST_SUM_OK;
            res.byte_total = sum;
          end else if (last) begin
            res_vld = 1'b1;
            res.status = ST_TRUNCATED;
          end
        end
      end
      PH_DROP: begin
      end
      default: begin
      end
    endcase
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (res_vld) begin
      phase_d = last ? PH_START : PH_DROP;
    end else begin
      unique case (phase_q)
        PH_START:   phase_d = PH_CMD;
        PH_CMD:     phase_d = PH_LEN;
        PH_LEN:     phase_d = PH_PAYLOAD;
        PH_PAYLOAD: phase_d = PH_PAYLOAD;
        PH_DROP:    phase_d = last ? PH_START : PH_DROP;
        default:    phase_d = PH_START;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= StartMarkerRst;
      phase_q  <= PH_START;
      kind_q   <= CMD_SUM;
      len_q    <= '0;
      seen_q   <= '0;
      total_q  <= '0;
      on_q     <= '0;
      off_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        marker_q <= cfg_data_i;
      end
      if (in_fire) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        len_q   <= len_d;
        seen_q  <= seen_d;
        total_q <= total_d;
        on_q    <= on_d;
        off_q   <= off_d;
      end
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_fire && res_vld) begin
      if (out_vld_q && !out_ready_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_vld) begin
      if (out_vld_q && !out_ready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // Checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty output register");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_DROP) |-> !res_vld)
    else $error("word produced while dropping frame tail");

  a_drop_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_vld && !last) |=> phase_q == PH_DROP)
    else $error("frame not dropped after its status word");

  a_blink_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD && kind_q == CMD_FLASH) |-> seen_q <= 8'd2)
    else $error("blink payload index out of range");

endmodule
